// ----- src/bee_pkg.sv -----
package bee_pkg;

  localparam int MAX_SAMPLE_DEF = 65536;
  localparam int FRAC_BITS      = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam logic [15:0] ENTROPY_MAX   = 16'd32768;
  localparam logic [15:0] THRESH_RESET  = 16'd28672;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] entropy;
    logic        high_entropy;
    logic [16:0] sample_count;
  } result_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

endpackage

// ----- src/bee_ram.sv -----
module bee_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bee_front.sv -----
module bee_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bee_pkg::in_item_t item,
  input  logic              hold,
  output logic              busy,
  output bee_pkg::q_head_t  head,
  input  logic              pop
);

  localparam int Aw = $clog2(bee_pkg::QUEUE_DEPTH);

  bee_pkg::in_item_t q [bee_pkg::QUEUE_DEPTH];
  logic [Aw-1:0] wptr;
  logic [Aw-1:0] rptr;
  logic [Aw:0]   count;
  logic          push;
  logic          do_pop;

  assign busy   = hold || (count == (Aw+1)'(bee_pkg::QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(do_pop);
    end
  end

endmodule

// ----- src/bee_log.sv -----
module bee_log #(
  parameter int CntW = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [CntW-1:0]           x,
  output logic                      done,
  output logic [$clog2(CntW)+bee_pkg::FRAC_BITS-1:0] l
);

  localparam int Eb = $clog2(CntW);
  localparam int Fb = bee_pkg::FRAC_BITS;

  typedef enum logic [1:0] {IDLE, NORM, SQ, UPD} state_t;

  state_t                state;
  logic [31:0]           m;
  logic [63:0]           p;
  logic [Eb-1:0]         e;
  logic [Fb-1:0]         frac;
  logic [$clog2(Fb)-1:0] cnt;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (go) begin
            m     <= {x, {(32-CntW){1'b0}}};
            e     <= Eb'(CntW-1);
            frac  <= '0;
            cnt   <= '0;
            state <= NORM;
          end
        end
        NORM: begin
          // shift until the top bit lands at bit 31
          if (m[31]) begin
            state <= SQ;
          end else begin
            m <= m << 1;
            e <= e - 1'b1;
          end
        end
        SQ: begin
          p     <= m * m;
          state <= UPD;
        end
        UPD: begin
          if (p[63]) begin
            m    <= p[63:32];
            frac <= {frac[Fb-2:0], 1'b1};
          end else begin
            m    <= p[62:31];
            frac <= {frac[Fb-2:0], 1'b0};
          end
          if (cnt == ($clog2(Fb))'(Fb-1)) begin
            state <= IDLE;
            done  <= 1'b1;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= SQ;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign l = {e, frac};

endmodule

// ----- src/bee_back.sv -----
module bee_back #(
  parameter int MaxSample = bee_pkg::MAX_SAMPLE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bee_pkg::q_head_t  head,
  output logic              pop,
  output logic              clearing,
  input  logic [15:0]       threshold,
  output logic              done,
  output bee_pkg::result_t  result
);

  localparam int Cw = $clog2(MaxSample+1);
  localparam int Lw = $clog2(Cw) + bee_pkg::FRAC_BITS;
  localparam int Pw = Cw + Lw;
  localparam int Sw = Pw + 8;
  localparam int Dc = $clog2(Sw);

  typedef enum logic [3:0] {
    CLR, IDLE, INC, SUM_START, SUM_RD, SUM_LOG, NL_LOG, MUL, DIV_START, DIV, FIN
  } state_t;

  state_t         state;
  logic [7:0]     idx;
  logic [Cw-1:0]  total;
  logic [7:0]     cur_byte;
  logic           cur_last;
  logic [Cw-1:0]  c;
  logic [Sw-1:0]  s;
  logic [Pw-1:0]  t;
  logic [Pw-1:0]  ma;
  logic [Cw-1:0]  mb;
  logic           tsel;
  logic [Sw-1:0]  num;
  logic [Cw-1:0]  rem;
  logic [Lw-1:0]  q;
  logic [Dc-1:0]  dcnt;
  logic [Cw:0]    r2;
  logic [Lw-13:0] h;

  logic           log_go;
  logic [Cw-1:0]  log_x;
  logic           log_done;
  logic [Lw-1:0]  log_l;

  logic           we;
  logic [7:0]     waddr;
  logic [Cw-1:0]  wdata;
  logic [7:0]     raddr;
  logic [Cw-1:0]  rdata;

  bee_ram #(.Width(Cw), .Depth(256)) u_hist (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bee_log #(.CntW(Cw)) u_log (
    .clk, .rst, .go(log_go), .x(log_x), .done(log_done), .l(log_l)
  );

  assign clearing = (state == CLR);
  assign r2 = {rem, num[Sw-1]};
  assign h  = q[Lw-1:12];

  always_comb begin
    pop    = 1'b0;
    we     = 1'b0;
    waddr  = idx;
    wdata  = '0;
    raddr  = idx;
    log_go = 1'b0;
    log_x  = rdata;
    case (state)
      CLR: we = 1'b1;
      IDLE: begin
        pop   = head.valid;
        raddr = head.item.data_byte;
      end
      INC: begin
        we    = 1'b1;
        waddr = cur_byte;
        wdata = rdata + 1'b1;
      end
      SUM_START: raddr = '0;
      SUM_RD: begin
        // clear the bin as it is read out
        we     = 1'b1;
        raddr  = idx + 1'b1;
        log_go = (rdata != '0);
      end
      SUM_LOG: raddr = idx + 1'b1;
      MUL: raddr = idx + 1'b1;
      default: ;
    endcase
    // last bin done: start log2 of the total
    if ((state == SUM_RD && rdata == '0 && idx == 8'hff) ||
        (state == MUL && mb == '0 && !tsel && idx == 8'hff)) begin
      log_go = 1'b1;
      log_x  = total;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= CLR;
      idx   <= '0;
      total <= '0;
    end else begin
      case (state)
        CLR: begin
          idx <= idx + 1'b1;
          if (idx == 8'hff) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (head.valid) begin
            cur_byte <= head.item.data_byte;
            cur_last <= head.item.last;
            if (total < Cw'(MaxSample)) begin
              state <= INC;
            end else if (head.item.last) begin
              state <= SUM_START;
            end
          end
        end
        INC: begin
          total <= total + 1'b1;
          state <= cur_last ? SUM_START : IDLE;
        end
        SUM_START: begin
          idx <= '0;
          s   <= '0;
          if (total == '0) begin
            state <= FIN;
          end else begin
            state <= SUM_RD;
          end
        end
        SUM_RD: begin
          c <= rdata;
          if (rdata != '0) begin
            state <= SUM_LOG;
          end else if (idx == 8'hff) begin
            state <= NL_LOG;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        SUM_LOG: begin
          if (log_done) begin
            ma    <= Pw'(log_l);
            mb    <= c;
            tsel  <= 1'b0;
            state <= MUL;
          end
        end
        NL_LOG: begin
          if (log_done) begin
            ma    <= Pw'(log_l);
            mb    <= total;
            tsel  <= 1'b1;
            t     <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          // shift-add product, one multiplier bit per cycle
          if (mb == '0) begin
            if (tsel) begin
              state <= DIV_START;
            end else if (idx == 8'hff) begin
              state <= NL_LOG;
            end else begin
              idx   <= idx + 1'b1;
              state <= SUM_RD;
            end
          end else begin
            if (mb[0]) begin
              if (tsel) begin
                t <= t + ma;
              end else begin
                s <= s + Sw'(ma);
              end
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        DIV_START: begin
          num   <= (Sw'(t) > s) ? (Sw'(t) - s) : '0;
          rem   <= '0;
          q     <= '0;
          dcnt  <= '0;
          state <= DIV;
        end
        DIV: begin
          if (r2 >= {1'b0, total}) begin
            rem <= Cw'(r2 - {1'b0, total});
            q   <= {q[Lw-2:0], 1'b1};
          end else begin
            rem <= r2[Cw-1:0];
            q   <= {q[Lw-2:0], 1'b0};
          end
          num  <= num << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == Dc'(Sw-1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          state <= IDLE;
          done  <= 1'b1;
        end
        default: state <= IDLE;
      endcase
      if (state == FIN) begin
        total <= '0;
      end
    end
  end

  // saturate at 8.0 bits per byte
  logic [15:0] ent_out;
  assign ent_out = (h > (Lw-12)'(bee_pkg::ENTROPY_MAX)) ? bee_pkg::ENTROPY_MAX : h[15:0];

  always_ff @(posedge clk) begin
    if (state == FIN) begin
      result.entropy      <= (total == '0) ? 16'd0 : ent_out;
      result.high_entropy <= ((total == '0) ? 16'd0 : ent_out) > threshold;
      result.sample_count <= 17'(total);
    end
  end

  assert property (@(posedge clk) disable iff (rst) total <= Cw'(MaxSample))
    else $error("sample count above limit");
  assert property (@(posedge clk) disable iff (rst) pop |-> state == IDLE)
    else $error("queue popped outside idle");
  assert property (@(posedge clk) disable iff (rst) done |-> state == IDLE)
    else $error("result beat not followed by idle");
  assert property (@(posedge clk) disable iff (rst) log_go |=> state != IDLE)
    else $error("log started from idle");

endmodule

// ----- src/byte_entropy_estimator.sv -----
// channel  | signals                    | handshake
// input    | start, busy, item          | beat taken when start && !busy
// result   | done, result               | one-cycle strobe, never held off
// config   | cfg_we, cfg_data           | written when cfg_we is high
//
// a byte goes through the histogram read-modify-write in states IDLE then INC (ram port pair),
// a four-beat queue absorbs short bursts.
// the last byte starts a sweep of 256 bins: an iterative log2 per nonzero bin
// (one 32x32 squarer), then a shift-add product, and after the sweep
// n*log2(n) and the bit-serial divide.
// after reset busy stays high while the histogram is cleared.
// the result receiver cannot stall; busy rises once the queue fills during the sweep.
module byte_entropy_estimator #(
  parameter int MaxSample = bee_pkg::MAX_SAMPLE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bee_pkg::in_item_t item,
  output logic              done,
  output bee_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);

  logic [15:0]      thr;
  bee_pkg::q_head_t head;
  logic             pop;
  logic             clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= bee_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  bee_front u_front (
    .clk, .rst, .start, .item, .hold(clearing), .busy, .head, .pop
  );

  bee_back #(.MaxSample(MaxSample)) u_back (
    .clk, .rst, .head, .pop, .clearing, .threshold(thr), .done, .result
  );

endmodule
